// File: rtl/core/jrb_pkg.sv
// ---------------------------------------------------------------------------
// jrb_pkg
// Shared types and constants for the join retry backoff controller.
// ---------------------------------------------------------------------------
package jrb_pkg;

    // Field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DELAY_W   = 24;
    localparam int unsigned TICKS_W   = 8;
    localparam int unsigned FAIL_W    = 3;
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned SLEEP_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NUM_DELAY = 5;

    // Stream widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 48;

    // Reset values of the configuration registers
    localparam logic [TICKS_W-1:0] TIMEOUT_RST   = 8'd120;
    localparam logic [DELAY_W-1:0] DELAY1_RST    = 24'd1800;
    localparam logic [DELAY_W-1:0] DELAY2_RST    = 24'd3600;
    localparam logic [DELAY_W-1:0] DELAY3_RST    = 24'd7200;
    localparam logic [DELAY_W-1:0] DELAY4_RST    = 24'd28800;
    localparam logic [DELAY_W-1:0] DELAY_CAP_RST = 24'd86400;

    // Failure count saturates here
    localparam logic [FAIL_W-1:0] FAIL_MAX = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JOIN_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_THIRD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FOURTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_CAP    = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_WAIT   = 3'd2,
        PH_JOINED = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_JOIN    = 3'd1,
        ACT_SYNC    = 3'd2,
        ACT_TIMEOUT = 3'd3,
        ACT_SLEEP   = 3'd4
    } action_t;

    typedef enum logic [SLEEP_W-1:0] {
        SLP_NONE   = 2'd0,
        SLP_RAISE  = 2'd1,
        SLP_NORMAL = 2'd2
    } sleep_t;

    // Configuration seen by the controller
    typedef struct packed {
        logic [TICKS_W-1:0] join_timeout;
        logic [DELAY_W-1:0] delay_first;
        logic [DELAY_W-1:0] delay_second;
        logic [DELAY_W-1:0] delay_third;
        logic [DELAY_W-1:0] delay_fourth;
        logic [DELAY_W-1:0] delay_cap;
    } cfg_t;

    // Result beat; last member lands in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] retry_at;
        logic [FAIL_W-1:0] failures;
        logic              link_error;
        logic              joined_flag;
        sleep_t            sleep_delay_action;
        action_t           action;
    } res_t;

endpackage

// File: rtl/core/jrb_cfg.sv
// ---------------------------------------------------------------------------
// jrb_cfg
// Configuration register file: join timeout and five retry delays.
// ---------------------------------------------------------------------------
module jrb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jrb_pkg::DELAY_W-1:0]   cfg_data,
    output jrb_pkg::cfg_t                 cfg
);
    import jrb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the index; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_JOIN_TIMEOUT: cfg_next.join_timeout = cfg_data[TICKS_W-1:0];
                REG_DELAY_FIRST:  cfg_next.delay_first  = cfg_data;
                REG_DELAY_SECOND: cfg_next.delay_second = cfg_data;
                REG_DELAY_THIRD:  cfg_next.delay_third  = cfg_data;
                REG_DELAY_FOURTH: cfg_next.delay_fourth = cfg_data;
                REG_DELAY_CAP:    cfg_next.delay_cap    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.join_timeout <= TIMEOUT_RST;
            cfg_reg.delay_first  <= DELAY1_RST;
            cfg_reg.delay_second <= DELAY2_RST;
            cfg_reg.delay_third  <= DELAY3_RST;
            cfg_reg.delay_fourth <= DELAY4_RST;
            cfg_reg.delay_cap    <= DELAY_CAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/jrb_fsm.sv
// ---------------------------------------------------------------------------
// jrb_fsm
// Join phase machine: advances the controller state by one tick per step.
// ---------------------------------------------------------------------------
module jrb_fsm (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [jrb_pkg::TIME_W-1:0] now_seconds,
    input  logic                       join_confirmed,
    input  jrb_pkg::cfg_t              cfg,
    output jrb_pkg::res_t              res
);
    import jrb_pkg::*;

    phase_t              phase_reg,        phase_next;
    logic [TICKS_W-1:0]  wait_count_reg,   wait_count_next;
    logic [FAIL_W-1:0]   fail_count_reg,   fail_count_next;
    logic [TIME_W-1:0]   retry_time_reg,   retry_time_next;
    logic                error_flag_reg,   error_flag_next;
    logic                joined_state_reg, joined_state_next;

    logic [TICKS_W-1:0]  wait_inc;
    logic                timeout_hit;
    logic                retry_due;
    logic [FAIL_W-1:0]   fail_inc;
    logic [DELAY_W-1:0]  delay_sel;
    logic [TIME_W:0]     retry_sum;
    logic [TIME_W-1:0]   retry_sat;
    action_t             action;
    sleep_t              sleep_act;

    // Shared datapath terms
    assign wait_inc    = (wait_count_reg == {TICKS_W{1'b1}}) ? wait_count_reg
                                                             : wait_count_reg + 1'b1;
    assign timeout_hit = (wait_inc >= cfg.join_timeout);
    assign retry_due   = (retry_time_reg <= now_seconds);
    assign fail_inc    = (fail_count_reg >= FAIL_MAX) ? FAIL_MAX : fail_count_reg + 1'b1;

    // Pick the delay for the new failure count
    always_comb begin
        case (fail_inc)
            3'd1:    delay_sel = cfg.delay_first;
            3'd2:    delay_sel = cfg.delay_second;
            3'd3:    delay_sel = cfg.delay_third;
            3'd4:    delay_sel = cfg.delay_fourth;
            default: delay_sel = cfg.delay_cap;
        endcase
    end

    // Saturating add of the delay to the current time
    assign retry_sum = {1'b0, now_seconds} + {{(TIME_W+1-DELAY_W){1'b0}}, delay_sel};
    assign retry_sat = retry_sum[TIME_W] ? {TIME_W{1'b1}} : retry_sum[TIME_W-1:0];

    // Next phase
    always_comb begin
        case (phase_reg)
            PH_IDLE:   phase_next = (error_flag_reg && retry_due) ? PH_START : PH_IDLE;
            PH_START:  phase_next = PH_WAIT;
            PH_WAIT: begin
                if (join_confirmed) begin
                    phase_next = PH_JOINED;
                end else if (timeout_hit) begin
                    phase_next = PH_ERROR;
                end else begin
                    phase_next = PH_WAIT;
                end
            end
            PH_JOINED: phase_next = PH_IDLE;
            PH_ERROR:  phase_next = PH_IDLE;
            default:   phase_next = phase_reg;
        endcase
    end

    // Commands and datapath state per phase
    always_comb begin
        action            = ACT_NONE;
        sleep_act         = SLP_NONE;
        wait_count_next   = wait_count_reg;
        fail_count_next   = fail_count_reg;
        retry_time_next   = retry_time_reg;
        error_flag_next   = error_flag_reg;
        joined_state_next = joined_state_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (error_flag_reg && retry_due) begin
                    sleep_act = SLP_RAISE;
                end
            end
            PH_START: begin
                joined_state_next = 1'b0;
                wait_count_next   = '0;
                action            = ACT_JOIN;
            end
            PH_WAIT: begin
                if (!join_confirmed) begin
                    if (timeout_hit) begin
                        wait_count_next = '0;
                        error_flag_next = 1'b1;
                        sleep_act       = SLP_NORMAL;
                        action          = ACT_TIMEOUT;
                    end else begin
                        wait_count_next = wait_inc;
                    end
                end
            end
            PH_JOINED: begin
                joined_state_next = 1'b1;
                fail_count_next   = '0;
                wait_count_next   = '0;
                error_flag_next   = 1'b0;
                sleep_act         = SLP_NORMAL;
                action            = ACT_SYNC;
            end
            PH_ERROR: begin
                error_flag_next = 1'b1;
                sleep_act       = SLP_NORMAL;
                action          = ACT_SLEEP;
                if (retry_due) begin
                    fail_count_next = fail_inc;
                    retry_time_next = retry_sat;
                end
            end
            default: begin
                action = ACT_NONE;
            end
        endcase
    end

    // Advance the state on each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            wait_count_reg   <= '0;
            fail_count_reg   <= '0;
            retry_time_reg   <= '0;
            error_flag_reg   <= 1'b1;
            joined_state_reg <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            wait_count_reg   <= wait_count_next;
            fail_count_reg   <= fail_count_next;
            retry_time_reg   <= retry_time_next;
            error_flag_reg   <= error_flag_next;
            joined_state_reg <= joined_state_next;
        end
    end

    // Result shows the state after this tick
    always_comb begin
        res.action             = action;
        res.sleep_delay_action = sleep_act;
        res.joined_flag        = joined_state_next;
        res.link_error         = error_flag_next;
        res.failures           = fail_count_next;
        res.retry_at           = retry_time_next;
    end

endmodule

// File: rtl/core/join_retry_backoff_fsm.sv
// ---------------------------------------------------------------------------
// join_retry_backoff_fsm
// Network join controller with timeout and failure backoff, one tick a beat.
// ---------------------------------------------------------------------------
// Each input beat is one one-second tick (time and join status) and gives
// exactly one result beat: a command code, a sleep-delay action, the joined
// and error flags, the failure count and the retry time. A new tick can be
// taken every clock cycle. A tick passes through an input register and then
// a result register, so its result beat is valid once the tick has moved on
// into the result register. One tick and one result can wait inside;
// the input stalls only when both registers are full and the result beat is
// not taken in that cycle. The configuration channel takes a write every
// cycle; write it only while no tick is in flight.
module join_retry_backoff_fsm (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jrb_pkg::S_DATA_W-1:0]  s_tdata,   // now_seconds, join_confirmed
    // Result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // action, sleep_delay_action, joined_flag, link_error, failures, retry_at
    output logic [jrb_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jrb_pkg::DELAY_W-1:0]   cfg_data
);
    import jrb_pkg::*;

    cfg_t              cfg;
    res_t              res;

    logic              in_valid_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_conf_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              advance;

    jrb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held tick into the result register when it is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    jrb_fsm u_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .now_seconds    (in_now_reg),
        .join_confirmed (in_conf_reg),
        .cfg            (cfg),
        .res            (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg  <= s_tdata[TIME_W-1:0];
            in_conf_reg <= s_tdata[TIME_W];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-$bits(res_t)){1'b0}}, out_res_reg};

endmodule
